@@ rtl/sstq_pkg.sv @@
// Package for the sorted sleep timer queue: field widths, time scale constants.
// No dependencies; imported by the top level, sorted_sleep_timer_queue_unit.
package sstq_pkg;

  localparam int unsigned SLOTS_DEF = 64;   // default slot count
  localparam int unsigned MAX_OUT   = 64;   // releases per tick at most
  localparam int unsigned ID_W      = 16;
  localparam int unsigned SECS_W    = 16;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned WAKE_W    = 40;
  localparam int unsigned SECS_MS   = 1000; // milliseconds per second
  localparam int unsigned TICK_MS   = 100;  // milliseconds per tick
  localparam int unsigned PS_W      = SECS_W + 10; // seconds product width
  localparam int unsigned PT_W      = TICK_W + 7;  // tick product width
  localparam int unsigned CNT_W     = $clog2(MAX_OUT);

endpackage

@@ rtl/sstq_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data.
// A read of the address written in the same cycle returns the new data.
module sstq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sorted_sleep_timer_queue_unit.sv @@
// Sorted sleep timer queue, top level.
// Uses sstq_pkg and three sstq_ram instances (wake time, owner, link).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per
//   request: func_i = 0 is a sleep request (process_id_i, sleep_seconds_i),
//   func_i = 1 is a clock tick. Output channel (out_valid_o / out_stall_i)
//   carries one transaction per woken process, last_of_run_o marking the
//   final release of a tick. A sleep request produces no output.
//   The block works on one request at a time; in_stall_o is high while a
//   request is in progress.
// Sequencing:
//   Sleep: the id is reduced to its slot (reciprocal multiply in ST_MOD, then
//   subtract in ST_MOD_SUB), then the queue is walked one entry per cycle to
//   unlink an old entry of the same slot, and again one entry per cycle to
//   find the insertion point.
//   Tick: one entry is released per cycle unless the output stalls (up to
//   64), each release being a read of the linked-list memory.
// Reset: tick counter cleared, queue empty. Entry memories are not cleared;
//   an entry is read only after a sleep request has written it.
// Receiver stall: the output register holds its transaction; the release
//   walk pauses with its memory read held until the register frees.
module sorted_sleep_timer_queue_unit
  import sstq_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [ID_W-1:0]   process_id_i,
  input  logic [SECS_W-1:0] sleep_seconds_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ID_W-1:0]   woken_process_o,
  output logic              last_of_run_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned LINK_W = $clog2(SLOTS + 1);
  localparam logic [LINK_W-1:0] NIL     = LINK_W'(SLOTS);
  // slot = id - floor(id * MOD_MUL / 2^MOD_SH) * SLOTS, exact for every id
  localparam int unsigned MOD_SH = ID_W + $clog2(SLOTS);
  localparam int unsigned MUL_W  = ID_W + 2;
  localparam int unsigned PROD_W = MOD_SH + ID_W;
  localparam logic [MUL_W-1:0] MOD_MUL =
    MUL_W'(((64'd1 << MOD_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_MOD_SUB, ST_TO_START, ST_TO_HEAD, ST_TO_WALK, ST_TO_UNLINK,
    ST_INS_START, ST_INS_CMP, ST_INS_WALK, ST_INS_LINK,
    ST_TK_MUL, ST_TK_HEAD, ST_TK_FIRST, ST_TK_NEXT, ST_TK_LAST
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LINK_W-1:0] head_q, head_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic              func_q;
  logic [ID_W-1:0]   id_q, quot_q, quot_d;
  logic [SECS_W-1:0] secs_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] nxt_q, nxt_d;
  logic [ID_W-1:0]   cand_q, cand_d;
  logic [PS_W-1:0]   prod_s_q;
  logic [PT_W-1:0]   prod_t_q;
  logic [WAKE_W-1:0] wake_q;
  logic              out_valid_q;
  logic [ID_W-1:0]   out_id_q;
  logic              out_last_q;

  // memory ports
  logic [SLOT_W-1:0] raddr;
  logic              ent_we;
  logic              link_we;
  logic [SLOT_W-1:0] link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [WAKE_W-1:0] rd_wake;
  logic [ID_W-1:0]   rd_owner;
  logic [LINK_W-1:0] rd_link;

  logic              accept, out_free, emit, emit_last, qual;
  logic [PROD_W-1:0] mod_prod;
  logic [ID_W-1:0]   mod_sub;
  logic [WAKE_W-1:0] now;
  logic [LINK_W-1:0] slot_ext;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign now       = WAKE_W'(prod_t_q);
  assign slot_ext  = LINK_W'(slot_q);
  assign mod_prod  = PROD_W'(id_q) * PROD_W'(MOD_MUL);
  assign mod_sub   = id_q - ID_W'(quot_q * SLOTS);
  assign qual      = (now >= rd_wake) && (cnt_q < CNT_W'(MAX_OUT - 1));

  sstq_ram #(.DEPTH(SLOTS), .WIDTH(WAKE_W)) u_wake_ram (
    .clk_i, .we_i(ent_we), .waddr_i(slot_q), .wdata_i(wake_q),
    .raddr_i(raddr), .rdata_o(rd_wake)
  );
  sstq_ram #(.DEPTH(SLOTS), .WIDTH(ID_W)) u_owner_ram (
    .clk_i, .we_i(ent_we), .waddr_i(slot_q), .wdata_i(id_q),
    .raddr_i(raddr), .rdata_o(rd_owner)
  );
  sstq_ram #(.DEPTH(SLOTS), .WIDTH(LINK_W)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .raddr_i(raddr), .rdata_o(rd_link)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    head_d     = head_q;
    tick_d     = tick_q;
    quot_d     = quot_q;
    slot_d     = slot_q;
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    cand_d     = cand_q;
    raddr      = head_q[SLOT_W-1:0];
    ent_we     = 1'b0;
    link_we    = 1'b0;
    link_waddr = slot_q;
    link_wdata = NIL;
    emit       = 1'b0;
    emit_last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i) begin
            tick_d  = tick_q + 1'b1;
            state_d = ST_TK_MUL;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      // quotient by reciprocal multiplication
      ST_MOD: begin
        quot_d  = mod_prod[PROD_W-1:MOD_SH];
        state_d = ST_MOD_SUB;
      end
      // remainder: slot = id modulo SLOTS
      ST_MOD_SUB: begin
        slot_d  = SLOT_W'(mod_sub);
        state_d = ST_TO_START;
      end
      ST_TO_START: begin
        if (head_q == NIL) begin
          state_d = ST_INS_START;
        end else if (head_q == slot_ext) begin
          raddr   = slot_q;
          state_d = ST_TO_HEAD;
        end else begin
          cur_d   = head_q[SLOT_W-1:0];
          state_d = ST_TO_WALK;
        end
      end
      ST_TO_HEAD: begin
        head_d  = rd_link;
        state_d = ST_INS_START;
      end
      ST_TO_WALK: begin
        if (rd_link == NIL) begin
          state_d = ST_INS_START;
        end else if (rd_link == slot_ext) begin
          raddr   = slot_q;
          state_d = ST_TO_UNLINK;
        end else begin
          cur_d = rd_link[SLOT_W-1:0];
          raddr = rd_link[SLOT_W-1:0];
        end
      end
      ST_TO_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = rd_link;
        state_d    = ST_INS_START;
      end
      ST_INS_START: begin
        ent_we = 1'b1;
        if (head_q == NIL) begin
          link_we = 1'b1;
          head_d  = slot_ext;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        cur_d = head_q[SLOT_W-1:0];
        if (wake_q < rd_wake) begin
          link_we    = 1'b1;
          link_wdata = head_q;
          head_d     = slot_ext;
          state_d    = ST_IDLE;
        end else if (rd_link == NIL) begin
          link_we = 1'b1;
          state_d = ST_INS_LINK;
        end else begin
          nxt_d   = rd_link;
          raddr   = rd_link[SLOT_W-1:0];
          state_d = ST_INS_WALK;
        end
      end
      // equal wake times stay ahead of the new entry
      ST_INS_WALK: begin
        if (rd_wake > wake_q) begin
          link_we    = 1'b1;
          link_wdata = nxt_q;
          state_d    = ST_INS_LINK;
        end else begin
          cur_d = nxt_q[SLOT_W-1:0];
          if (rd_link == NIL) begin
            link_we = 1'b1;
            state_d = ST_INS_LINK;
          end else begin
            nxt_d = rd_link;
            raddr = rd_link[SLOT_W-1:0];
          end
        end
      end
      ST_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = slot_ext;
        state_d    = ST_IDLE;
      end
      ST_TK_MUL: begin
        state_d = ST_TK_HEAD;
      end
      ST_TK_HEAD: begin
        state_d = (head_q == NIL) ? ST_IDLE : ST_TK_FIRST;
      end
      ST_TK_FIRST: begin
        if (now >= rd_wake) begin
          cand_d = rd_owner;
          head_d = rd_link;
          cnt_d  = '0;
          if (rd_link == NIL) begin
            state_d = ST_TK_LAST;
          end else begin
            raddr   = rd_link[SLOT_W-1:0];
            state_d = ST_TK_NEXT;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      // hold the read of the new head while the output register is full
      ST_TK_NEXT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = !qual;
          if (qual) begin
            cand_d = rd_owner;
            head_d = rd_link;
            cnt_d  = cnt_q + 1'b1;
            if (rd_link == NIL) begin
              state_d = ST_TK_LAST;
            end else begin
              raddr = rd_link[SLOT_W-1:0];
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TK_LAST: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      head_q      <= NIL;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      tick_q  <= tick_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      id_q   <= process_id_i;
      secs_q <= sleep_seconds_i;
    end
    quot_q   <= quot_d;
    slot_q   <= slot_d;
    cur_q    <= cur_d;
    nxt_q    <= nxt_d;
    cand_q   <= cand_d;
    prod_s_q <= PS_W'(secs_q) * PS_W'(SECS_MS);
    prod_t_q <= PT_W'(tick_q) * PT_W'(TICK_MS);
    wake_q   <= WAKE_W'(prod_s_q) + WAKE_W'(prod_t_q);
    if (emit) begin
      out_id_q   <= cand_q;
      out_last_q <= emit_last;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign woken_process_o = out_id_q;
  assign last_of_run_o   = out_last_q;

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NIL)
    else $error("queue head beyond empty marker");

  a_sleep_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> func_q)
    else $error("release issued during a sleep request");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_OUT - 1))
    else $error("release count beyond per-tick limit");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || !out_stall_i))
    else $error("release overwrote a stalled result");

endmodule
